// ===== src/measurement_window_gate_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the measurement window gate
// Shared shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef MEASUREMENT_WINDOW_GATE_TOP_MACROS_SVH
`define MEASUREMENT_WINDOW_GATE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MWG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mwg_pkg.sv =====
// ----------------------------------------------------------------------------
// mwg_pkg
// Types, codes and helpers shared by the measurement window gate modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mwg_pkg;

    localparam int unsigned COUNT_WIDTH = 32;
    localparam int unsigned DATA_W      = 32;

    // Mask for counter deltas taken modulo 2^COUNT_WIDTH, limited to 32 bits.
    localparam logic [DATA_W-1:0] CNT_MASK = (COUNT_WIDTH >= DATA_W) ?
        {DATA_W{1'b1}} : DATA_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [1:0]        cmd_t;
    typedef logic [2:0]        phase_t;
    typedef logic [1:0]        verdict_t;
    typedef logic [1:0]        cwin_t;
    typedef logic [1:0]        cfg_idx_t;

    localparam cmd_t CMD_TICK  = 2'd0;
    localparam cmd_t CMD_START = 2'd1;
    localparam cmd_t CMD_ABORT = 2'd2;

    localparam phase_t PH_IDLE   = 3'd0;
    localparam phase_t PH_SETTLE = 3'd1;
    localparam phase_t PH_BASE   = 3'd2;
    localparam phase_t PH_TEST   = 3'd3;
    localparam phase_t PH_DONE   = 3'd4;

    localparam verdict_t V_NONE   = 2'd0;
    localparam verdict_t V_PASS   = 2'd1;
    localparam verdict_t V_FAIL   = 2'd2;
    localparam verdict_t V_INCONC = 2'd3;

    localparam cwin_t CW_NONE = 2'd0;
    localparam cwin_t CW_BASE = 2'd1;
    localparam cwin_t CW_TEST = 2'd2;

    localparam cfg_idx_t CFG_SETTLE = 2'd0;
    localparam cfg_idx_t CFG_WINDOW = 2'd1;
    localparam cfg_idx_t CFG_LEVEL  = 2'd2;

    localparam data_t SETTLE_RESET = 32'd1000;
    localparam data_t WINDOW_RESET = 32'd10000;
    localparam data_t LEVEL_RESET  = 32'd0;

    typedef struct packed {
        cmd_t  cmd;
        data_t now_ms;
        logic  playing;
        data_t sector_count;
        data_t underrun_count;
        data_t silence_count;
        data_t latency_us;
    } tick_t;

    typedef struct packed {
        phase_t   phase;
        verdict_t verdict;
        data_t    level_now;
        cwin_t    closed_window;
        data_t    win_ms;
        data_t    win_sectors;
        data_t    win_underruns;
        data_t    win_silence;
        data_t    win_worst_us;
    } result_t;

    function automatic data_t cnt_delta(input data_t cur, input data_t mark);
        return (cur - mark) & CNT_MASK;
    endfunction

endpackage

`default_nettype wire

// ===== src/mwg_in_stage.sv =====
// ----------------------------------------------------------------------------
// mwg_in_stage
// Input register: captures one tick word and holds it until it is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module mwg_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire mwg_pkg::tick_t s_word,
    input  wire logic          consume,
    output logic               word_valid,
    output mwg_pkg::tick_t     word
);
    import mwg_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    tick_t word_reg;

    assign s_ready    = !valid_reg || consume;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset; load on every accepted word.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

// ===== src/mwg_core.sv =====
// ----------------------------------------------------------------------------
// mwg_core
// Gate state, configuration registers and the per-tick update logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "measurement_window_gate_top_macros.svh"

module mwg_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire mwg_pkg::cfg_idx_t cfg_index,
    input  wire mwg_pkg::data_t    cfg_wdata,
    input  wire logic              step_en,
    input  wire mwg_pkg::tick_t    word,
    output mwg_pkg::result_t       result
);
    import mwg_pkg::*;

    data_t    settle_reg, window_reg, level_reg;
    phase_t   phase_reg, phase_next;
    verdict_t verdict_reg, verdict_next;
    logic     was_playing_reg, was_playing_next;
    data_t    start_reg, start_next;
    data_t    sector_mark_reg, sector_mark_next;
    data_t    underrun_mark_reg, underrun_mark_next;
    data_t    silence_mark_reg, silence_mark_next;
    data_t    worst_reg, worst_next;
    data_t    base_silence_reg, base_silence_next;

    data_t elapsed;
    data_t worst_upd;
    data_t d_sectors, d_underruns, d_silence;

    assign elapsed     = word.now_ms - start_reg;
    assign worst_upd   = (word.latency_us > worst_reg) ? word.latency_us : worst_reg;
    assign d_sectors   = cnt_delta(word.sector_count, sector_mark_reg);
    assign d_underruns = cnt_delta(word.underrun_count, underrun_mark_reg);
    assign d_silence   = cnt_delta(word.silence_count, silence_mark_reg);

    always_comb begin
        phase_next         = phase_reg;
        verdict_next       = verdict_reg;
        was_playing_next   = was_playing_reg;
        start_next         = start_reg;
        sector_mark_next   = sector_mark_reg;
        underrun_mark_next = underrun_mark_reg;
        silence_mark_next  = silence_mark_reg;
        worst_next         = worst_reg;
        base_silence_next  = base_silence_reg;
        result             = '0;

        case (word.cmd)
            CMD_START: begin
                verdict_next       = V_NONE;
                base_silence_next  = '0;
                was_playing_next   = 1'b0;
                phase_next         = PH_SETTLE;
                start_next         = word.now_ms;
                sector_mark_next   = '0;
                underrun_mark_next = '0;
                silence_mark_next  = '0;
                worst_next         = '0;
            end
            CMD_ABORT: begin
                phase_next   = PH_IDLE;
                verdict_next = V_NONE;
            end
            CMD_TICK: begin
                if (phase_reg != PH_IDLE && phase_reg != PH_DONE) begin
                    if (!word.playing || !was_playing_reg) begin
                        // restart settle and re-mark the counters
                        phase_next         = PH_SETTLE;
                        start_next         = word.now_ms;
                        sector_mark_next   = word.sector_count;
                        underrun_mark_next = word.underrun_count;
                        silence_mark_next  = word.silence_count;
                        worst_next         = '0;
                        was_playing_next   = word.playing;
                    end else begin
                        worst_next = worst_upd;
                        if (phase_reg == PH_SETTLE) begin
                            if (elapsed >= settle_reg) begin
                                phase_next         = PH_BASE;
                                start_next         = word.now_ms;
                                sector_mark_next   = word.sector_count;
                                underrun_mark_next = word.underrun_count;
                                silence_mark_next  = word.silence_count;
                                worst_next         = '0;
                            end
                        end else if (elapsed >= window_reg) begin
                            result.win_ms        = elapsed;
                            result.win_sectors   = d_sectors;
                            result.win_underruns = d_underruns;
                            result.win_silence   = d_silence;
                            result.win_worst_us  = worst_upd;
                            if (phase_reg == PH_BASE) begin
                                result.closed_window = CW_BASE;
                                base_silence_next    = d_silence;
                                phase_next           = PH_TEST;
                                start_next           = word.now_ms;
                                sector_mark_next     = word.sector_count;
                                underrun_mark_next   = word.underrun_count;
                                silence_mark_next    = word.silence_count;
                                worst_next           = '0;
                            end else begin
                                result.closed_window = CW_TEST;
                                phase_next           = PH_DONE;
                                if (base_silence_reg != '0) begin
                                    verdict_next = V_INCONC;
                                end else if (d_silence != '0) begin
                                    verdict_next = V_FAIL;
                                end else begin
                                    verdict_next = V_PASS;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
                // unused command code: report status only
            end
        endcase

        result.phase     = phase_next;
        result.verdict   = verdict_next;
        result.level_now = (phase_next == PH_TEST) ? level_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg        <= SETTLE_RESET;
            window_reg        <= WINDOW_RESET;
            level_reg         <= LEVEL_RESET;
            phase_reg         <= PH_IDLE;
            verdict_reg       <= V_NONE;
            was_playing_reg   <= 1'b0;
            start_reg         <= '0;
            sector_mark_reg   <= '0;
            underrun_mark_reg <= '0;
            silence_mark_reg  <= '0;
            worst_reg         <= '0;
            base_silence_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SETTLE: settle_reg <= cfg_wdata;
                    CFG_WINDOW: window_reg <= cfg_wdata;
                    CFG_LEVEL:  level_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (step_en) begin
                phase_reg         <= phase_next;
                verdict_reg       <= verdict_next;
                was_playing_reg   <= was_playing_next;
                start_reg         <= start_next;
                sector_mark_reg   <= sector_mark_next;
                underrun_mark_reg <= underrun_mark_next;
                silence_mark_reg  <= silence_mark_next;
                worst_reg         <= worst_next;
                base_silence_reg  <= base_silence_next;
            end
        end
    end

    `MWG_ASSERT_IMP(a_verdict_only_done, aclk, aresetn, verdict_reg != V_NONE, phase_reg == PH_DONE, "verdict set outside done phase")
    `MWG_ASSERT_IMP(a_test_close_done, aclk, aresetn, result.closed_window == CW_TEST, result.phase == PH_DONE && result.verdict != V_NONE, "test close without verdict")
    `MWG_ASSERT_IMP(a_no_close_zero, aclk, aresetn, result.closed_window == CW_NONE, result.win_ms == '0 && result.win_silence == '0 && result.win_worst_us == '0, "window fields set with no close")
    `MWG_ASSERT_NXT(a_start_settles, aclk, aresetn, step_en && word.cmd == CMD_START, phase_reg == PH_SETTLE && verdict_reg == V_NONE, "start did not enter settle")

endmodule

`default_nettype wire

// ===== src/mwg_out_stage.sv =====
// ----------------------------------------------------------------------------
// mwg_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mwg_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire mwg_pkg::result_t result,
    output logic                  can_load,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output mwg_pkg::result_t      m_word
);
    import mwg_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : ((valid_reg && m_ready) ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

endmodule

`default_nettype wire

// ===== src/measurement_window_gate_top.sv =====
// ----------------------------------------------------------------------------
// measurement_window_gate_top
// A/B measurement gate: settle, baseline window, test window, verdict.
// ----------------------------------------------------------------------------
// Each accepted input word (a tick, start or abort command, or an unused code)
// yields exactly one result word. A word passes through an input register, the
// update logic in the core, and a result register. Its result appears on the
// m_ ports once the word moves from the input register into the result
// register. A new word is taken every cycle as long as the result side keeps
// up; throughput is then one word per clock, set by the state update in the
// core (one 32-bit subtract and compare per window check). A waiting result
// holds the next word in the input register: the input register still takes
// one word while the result waits, then s_ready stays low until m_ready takes
// the result. Configuration writes via cfg_wr_en/cfg_index/cfg_wdata take
// effect at the next edge with no handshake; write them only while no word is
// in flight. Index 0 is settle time, 1 window time, 2 test level; other
// indexes are dropped. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module measurement_window_gate_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write port
    input  wire logic              cfg_wr_en,
    input  wire mwg_pkg::cfg_idx_t cfg_index,
    input  wire mwg_pkg::data_t    cfg_wdata,
    // input words
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mwg_pkg::cmd_t     s_cmd,
    input  wire mwg_pkg::data_t    s_now_ms,
    input  wire logic              s_playing,
    input  wire mwg_pkg::data_t    s_sector_count,
    input  wire mwg_pkg::data_t    s_underrun_count,
    input  wire mwg_pkg::data_t    s_silence_count,
    input  wire mwg_pkg::data_t    s_latency_us,
    // result words
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mwg_pkg::phase_t        m_phase,
    output mwg_pkg::verdict_t      m_verdict,
    output mwg_pkg::data_t         m_level_now,
    output mwg_pkg::cwin_t         m_closed_window,
    output mwg_pkg::data_t         m_win_ms,
    output mwg_pkg::data_t         m_win_sectors,
    output mwg_pkg::data_t         m_win_underruns,
    output mwg_pkg::data_t         m_win_silence,
    output mwg_pkg::data_t         m_win_worst_us
);
    import mwg_pkg::*;

    tick_t   s_word;
    tick_t   held_word;
    logic    held_valid;
    logic    out_can_load;
    logic    advance;
    result_t step_result;
    result_t out_word;

    // Pack the input ports into one word.
    assign s_word.cmd            = s_cmd;
    assign s_word.now_ms         = s_now_ms;
    assign s_word.playing        = s_playing;
    assign s_word.sector_count   = s_sector_count;
    assign s_word.underrun_count = s_underrun_count;
    assign s_word.silence_count  = s_silence_count;
    assign s_word.latency_us     = s_latency_us;

    // Advance the held word into the result register when there is room;
    // the core updates its state on the same edge.
    assign advance = held_valid && out_can_load;

    mwg_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .consume    (advance),
        .word_valid (held_valid),
        .word       (held_word)
    );

    mwg_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step_en   (advance),
        .word      (held_word),
        .result    (step_result)
    );

    mwg_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (step_result),
        .can_load (out_can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (out_word)
    );

    // Unpack the result word onto the output ports.
    assign m_phase         = out_word.phase;
    assign m_verdict       = out_word.verdict;
    assign m_level_now     = out_word.level_now;
    assign m_closed_window = out_word.closed_window;
    assign m_win_ms        = out_word.win_ms;
    assign m_win_sectors   = out_word.win_sectors;
    assign m_win_underruns = out_word.win_underruns;
    assign m_win_silence   = out_word.win_silence;
    assign m_win_worst_us  = out_word.win_worst_us;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: measurement window gate testbench
// Drives command and tick words into the gate, mirrors the settle/baseline/
// test sequencing in a local prediction, and checks every result word field
// by field, under random idling on both channels and a long result hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import mwg_pkg::*;

    // Command code with no meaning; the gate must leave its state untouched.
    localparam cmd_t     CMD_UNUSED  = 2'd3;
    // Register index with no register behind it; writes must be dropped.
    localparam cfg_idx_t CFG_SPARE   = 2'd3;
    localparam int       HOLD_CYCLES = 64;
    localparam int       DRAIN_WAIT  = 4;
    localparam int       CYCLE_LIMIT = 300000;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     cfg_wr_en;
    cfg_idx_t cfg_index;
    data_t    cfg_wdata;
    logic     s_valid;
    logic     s_ready;
    cmd_t     s_cmd;
    data_t    s_now_ms;
    logic     s_playing;
    data_t    s_sector_count;
    data_t    s_underrun_count;
    data_t    s_silence_count;
    data_t    s_latency_us;
    logic     m_valid;
    logic     m_ready;
    phase_t   m_phase;
    verdict_t m_verdict;
    data_t    m_level_now;
    cwin_t    m_closed_window;
    data_t    m_win_ms;
    data_t    m_win_sectors;
    data_t    m_win_underruns;
    data_t    m_win_silence;
    data_t    m_win_worst_us;

    // Shadow copy of the configuration registers.
    data_t cfg_settle = SETTLE_RESET;
    data_t cfg_window = WINDOW_RESET;
    data_t cfg_level  = LEVEL_RESET;

    // Predicted gate state, reset values as after aresetn.
    phase_t   gate_phase        = PH_IDLE;
    verdict_t gate_verdict      = V_NONE;
    logic     gate_was_playing  = 1'b0;
    data_t    gate_start_ms     = '0;
    data_t    mark_sectors      = '0;
    data_t    mark_underruns    = '0;
    data_t    mark_silence      = '0;
    data_t    gate_worst_us     = '0;
    data_t    gate_base_silence = '0;

    // Result words the gate owes, oldest first.
    result_t report_q[$];

    int   error_count   = 0;
    int   cycle_count   = 0;
    bit   stall_en      = 1'b1;
    bit   hold_off_req  = 1'b0;

    measurement_window_gate_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_now_ms         (s_now_ms),
        .s_playing        (s_playing),
        .s_sector_count   (s_sector_count),
        .s_underrun_count (s_underrun_count),
        .s_silence_count  (s_silence_count),
        .s_latency_us     (s_latency_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_phase          (m_phase),
        .m_verdict        (m_verdict),
        .m_level_now      (m_level_now),
        .m_closed_window  (m_closed_window),
        .m_win_ms         (m_win_ms),
        .m_win_sectors    (m_win_sectors),
        .m_win_underruns  (m_win_underruns),
        .m_win_silence    (m_win_silence),
        .m_win_worst_us   (m_win_worst_us)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Enter a phase: stamp its start time, re-mark the counters and clear
    // the worst latency.
    function void open_phase(input phase_t ph, input data_t t, input data_t sec,
                             input data_t und, input data_t sil);
        gate_phase     = ph;
        gate_start_ms  = t;
        mark_sectors   = sec;
        mark_underruns = und;
        mark_silence   = sil;
        gate_worst_us  = '0;
    endfunction

    // Advance the predicted gate by one accepted word and return the result
    // word it must produce.
    function result_t gate_next_report(input tick_t w);
        result_t r;
        data_t   el;
        r = '0;
        if (w.cmd == CMD_START) begin
            gate_verdict      = V_NONE;
            gate_base_silence = '0;
            gate_was_playing  = 1'b0;
            open_phase(PH_SETTLE, w.now_ms, '0, '0, '0);
        end else if (w.cmd == CMD_ABORT) begin
            gate_phase   = PH_IDLE;
            gate_verdict = V_NONE;
        end else if (w.cmd == CMD_TICK && gate_phase != PH_IDLE && gate_phase != PH_DONE) begin
            if (!w.playing || !gate_was_playing) begin
                // Stopped transport or first playing tick: restart settle.
                open_phase(PH_SETTLE, w.now_ms, w.sector_count, w.underrun_count,
                           w.silence_count);
                gate_was_playing = w.playing;
            end else begin
                el = w.now_ms - gate_start_ms;
                if (w.latency_us > gate_worst_us)
                    gate_worst_us = w.latency_us;
                if (gate_phase == PH_SETTLE) begin
                    if (el >= cfg_settle)
                        open_phase(PH_BASE, w.now_ms, w.sector_count, w.underrun_count,
                                   w.silence_count);
                end else if (el >= cfg_window) begin
                    r.win_ms        = el;
                    r.win_sectors   = (w.sector_count - mark_sectors) & CNT_MASK;
                    r.win_underruns = (w.underrun_count - mark_underruns) & CNT_MASK;
                    r.win_silence   = (w.silence_count - mark_silence) & CNT_MASK;
                    r.win_worst_us  = gate_worst_us;
                    if (gate_phase == PH_BASE) begin
                        r.closed_window   = CW_BASE;
                        gate_base_silence = r.win_silence;
                        open_phase(PH_TEST, w.now_ms, w.sector_count, w.underrun_count,
                                   w.silence_count);
                    end else begin
                        r.closed_window = CW_TEST;
                        if (gate_base_silence != '0)
                            gate_verdict = V_INCONC;
                        else if (r.win_silence != '0)
                            gate_verdict = V_FAIL;
                        else
                            gate_verdict = V_PASS;
                        gate_phase = PH_DONE;
                    end
                end
            end
        end
        r.phase     = gate_phase;
        r.verdict   = gate_verdict;
        r.level_now = (gate_phase == PH_TEST) ? cfg_level : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    function void check_field(input string name, input data_t want, input data_t got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Compare every accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                $display("%0t: result word with nothing expected, expected none, actual phase %0d",
                         $time, m_phase);
                error_count++;
            end else begin
                want = report_q.pop_front();
                check_field("phase", data_t'(want.phase), data_t'(m_phase));
                check_field("verdict", data_t'(want.verdict), data_t'(m_verdict));
                check_field("level_now", want.level_now, m_level_now);
                check_field("closed_window", data_t'(want.closed_window),
                            data_t'(m_closed_window));
                check_field("win_ms", want.win_ms, m_win_ms);
                check_field("win_sectors", want.win_sectors, m_win_sectors);
                check_field("win_underruns", want.win_underruns, m_win_underruns);
                check_field("win_silence", want.win_silence, m_win_silence);
                check_field("win_worst_us", want.win_worst_us, m_win_worst_us);
            end
        end
    end

    // Drive m_ready: hold it low for a long stretch when asked, otherwise
    // drop it in short random bursts while stalling is enabled.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run with an error once the total cycle count passes CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word, with an optional idle burst first; hold it until the
    // gate takes it, then predict its result.
    task automatic send_word(input cmd_t c, input data_t t, input logic play, input data_t sec,
                             input data_t und, input data_t sil, input data_t lat);
        tick_t w;
        w.cmd            = c;
        w.now_ms         = t;
        w.playing        = play;
        w.sector_count   = sec;
        w.underrun_count = und;
        w.silence_count  = sil;
        w.latency_us     = lat;
        @(negedge aclk);
        if (stall_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_cmd            <= w.cmd;
        s_now_ms         <= w.now_ms;
        s_playing        <= w.playing;
        s_sector_count   <= w.sector_count;
        s_underrun_count <= w.underrun_count;
        s_silence_count  <= w.silence_count;
        s_latency_us     <= w.latency_us;
        do @(posedge aclk); while (!s_ready);
        report_q.push_back(gate_next_report(w));
    endtask

    // Stop offering words and wait until every owed result has come out,
    // then let the pipeline settle.
    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Reprogram all three registers while the gate is quiet.
    task automatic set_gate_config(input data_t settle, input data_t window, input data_t level);
        pause_until_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SETTLE;
        cfg_wdata <= settle;
        @(negedge aclk);
        cfg_index <= CFG_WINDOW;
        cfg_wdata <= window;
        @(negedge aclk);
        cfg_index <= CFG_LEVEL;
        cfg_wdata <= level;
        @(negedge aclk);
        // Unmapped index: the gate must drop this write.
        cfg_index <= CFG_SPARE;
        cfg_wdata <= $urandom;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_settle = settle;
        cfg_window = window;
        cfg_level  = level;
    endtask

    // One experiment: a start, then mostly playing ticks with random content
    // plus some stops, aborts, restarts and unused codes. Stop after one to
    // three words sent while the gate is idle or done.
    task automatic run_session(input int max_words, output int n_sent);
        data_t t, sec, und, sil, lat;
        logic  play;
        cmd_t  c;
        int    step_max, sil_mode, tail;
        t        = $urandom;
        sec      = $urandom;
        und      = $urandom;
        sil      = $urandom;
        sil_mode = $urandom_range(0, 2);
        tail     = $urandom_range(0, 2);
        step_max = (cfg_window > 400) ? 100 : int'(cfg_window) / 4 + 2;
        send_word(CMD_START, t, 1'($urandom_range(0, 1)), sec, und, sil, $urandom);
        n_sent = 1;
        while (n_sent < max_words && tail >= 0) begin
            case ($urandom_range(0, 39))
                0:       t += $urandom;
                1, 2:    t += 0;
                default: t += $urandom_range(0, step_max);
            endcase
            sec += ($urandom_range(0, 29) == 0) ? $urandom : $urandom_range(0, 40);
            und += ($urandom_range(0, 9) == 0) ? 1 : 0;
            // Silence mode 0 gives pass, 1 only fails the test window,
            // 2 mostly spoils the baseline.
            if ((sil_mode == 2 && $urandom_range(0, 7) == 0) ||
                (sil_mode == 1 && gate_phase == PH_TEST && $urandom_range(0, 2) == 0))
                sil += $urandom_range(1, 3);
            lat  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000);
            play = ($urandom_range(0, 24) != 0);
            case ($urandom_range(0, 99))
                0, 1:    c = CMD_ABORT;
                2, 3:    c = CMD_UNUSED;
                4:       c = CMD_START;
                default: c = CMD_TICK;
            endcase
            send_word(c, t, play, sec, und, sil, lat);
            n_sent++;
            if (gate_phase == PH_IDLE || gate_phase == PH_DONE)
                tail--;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle gate with reset configuration: ticks, unused codes and aborts
    // must leave it idle.
    task automatic test_idle_gate();
        send_word(CMD_TICK, 32'd1234, 1'b1, 32'd5, 32'd6, 32'd7, 32'd8);
        send_word(CMD_UNUSED, 32'd1300, 1'b1, '1, '1, '1, '1);
        send_word(CMD_ABORT, 32'd1400, 1'b0, '0, '0, '0, '0);
    endtask

    // Walk two full experiments by hand: time and counters wrap, worst
    // latency at full scale, a failing test window, then a spoiled baseline.
    task automatic test_directed_sessions();
        data_t t, sec, und, sil;
        set_gate_config(32'd5, 32'd10, '1);
        t   = 32'hFFFF_FFF8;
        sec = 32'hFFFF_FFF0;
        und = 32'hFFFF_FFFF;
        sil = '0;
        send_word(CMD_START, t, 1'b1, sec, und, sil, '0);
        send_word(CMD_TICK, t, 1'b0, sec, und, sil, 32'd10);
        send_word(CMD_TICK, t + 1, 1'b1, sec, und, sil, 32'd20);
        send_word(CMD_TICK, t + 6, 1'b1, sec + 3, und, sil, 32'd30);
        send_word(CMD_TICK, t + 9, 1'b1, sec + 32'h20, und + 1, sil, '1);
        send_word(CMD_TICK, t + 16, 1'b1, sec + 32'h40, und + 2, sil, 32'd7);
        send_word(CMD_TICK, t + 20, 1'b1, sec + 32'h50, und + 2, sil + 1, 32'd9);
        send_word(CMD_TICK, t + 27, 1'b1, sec + 32'h60, und + 3, sil + 1, 32'd4);
        // Done: ticks change nothing.
        send_word(CMD_TICK, t + 30, 1'b1, '0, '0, '0, '1);
        t = t + 40;
        send_word(CMD_START, t, 1'b0, sec, und, sil, '0);
        send_word(CMD_TICK, t + 1, 1'b1, sec, und, sil + 3, 32'd1);
        send_word(CMD_TICK, t + 6, 1'b1, sec + 1, und, sil + 3, 32'd2);
        send_word(CMD_TICK, t + 10, 1'b1, sec + 2, und, sil + 5, 32'd3);
        send_word(CMD_TICK, t + 16, 1'b1, sec + 3, und, sil + 5, 32'd2);
        send_word(CMD_TICK, t + 26, 1'b1, sec + 4, und, sil + 5, 32'd1);
        send_word(CMD_ABORT, t + 27, 1'b1, sec, und, sil, '0);
    endtask

    // Full-scale settle and window: settle and the baseline window each end
    // only at exactly the largest elapsed time.
    task automatic test_full_scale_times();
        set_gate_config('1, '1, '0);
        send_word(CMD_START, 32'd5, 1'b1, '0, '0, '0, '0);
        send_word(CMD_TICK, 32'd5, 1'b1, 32'd1, 32'd1, 32'd1, 32'd1);
        send_word(CMD_TICK, 32'd5 + 32'hFFFF_FFFE, 1'b1, 32'd2, 32'd1, 32'd1, 32'd1);
        send_word(CMD_TICK, 32'd4, 1'b1, 32'd3, 32'd1, 32'd1, 32'd1);
        send_word(CMD_TICK, 32'd3, 1'b1, 32'd9, 32'd4, 32'd1, 32'h8000_0000);
        send_word(CMD_ABORT, 32'd6, 1'b0, '0, '0, '0, '0);
    endtask

    // Hold results back long enough for the gate to fill and stall its input
    // while words keep coming.
    task automatic test_result_hold_off();
        int n;
        set_gate_config(32'd3, 32'd12, $urandom);
        stall_en     = 1'b1;
        hold_off_req = 1'b1;
        run_session(48, n);
        pause_until_drained();
    endtask

    // Random experiments over several register settings, zero among them.
    task automatic test_random_sessions();
        int n, sent;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_gate_config($urandom_range(0, 20), $urandom_range(1, 40), $urandom);
                1: set_gate_config('0, '0, '1);
                2: set_gate_config($urandom_range(0, 100), $urandom_range(50, 300), $urandom);
                default: set_gate_config($urandom_range(0, 8), $urandom_range(0, 8), $urandom);
            endcase
            sent = 0;
            while (sent < 350) begin
                // Choose at random between idling and back-to-back stretches.
                stall_en = ($urandom_range(0, 2) != 0);
                run_session(60, n);
                sent += n;
            end
        end
    endtask

    // Close with a steady stream: no idling on either side.
    task automatic test_steady_stream();
        int n, sent;
        set_gate_config(32'd10, 32'd30, $urandom);
        stall_en = 1'b0;
        sent     = 0;
        while (sent < 300) begin
            run_session(60, n);
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // Hold every input at a known value from time zero.
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_SETTLE;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_cmd            = CMD_TICK;
        s_now_ms         = '0;
        s_playing        = 1'b0;
        s_sector_count   = '0;
        s_underrun_count = '0;
        s_silence_count  = '0;
        s_latency_us     = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_gate();
        test_directed_sessions();
        test_full_scale_times();
        test_result_hold_off();
        test_random_sessions();
        test_steady_stream();

        // Drain the last results and give the pipeline time to show any
        // stray word.
        pause_until_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && report_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
